>>> rtl/core/bspc_pkg.sv
package bspc_pkg;

  localparam int unsigned WordBits = 32;

  localparam logic [1:0] ActWrite   = 2'd0;
  localparam logic [1:0] ActStep    = 2'd1;
  localparam logic [1:0] ActRestart = 2'd2;

  localparam logic [2:0] StRun     = 3'd0;
  localparam logic [2:0] StStop    = 3'd1;
  localparam logic [2:0] StCiOut   = 3'd2;
  localparam logic [2:0] StBadOp   = 3'd3;
  localparam logic [2:0] StDiv0    = 3'd4;
  localparam logic [2:0] StOpndOut = 3'd5;

  localparam logic [0:0] CfgExtSet   = 1'd0;
  localparam logic [0:0] CfgMemWords = 1'd1;

  localparam logic [3:0] OpJmp = 4'd0;
  localparam logic [3:0] OpJrp = 4'd1;
  localparam logic [3:0] OpLdn = 4'd2;
  localparam logic [3:0] OpSto = 4'd3;
  localparam logic [3:0] OpSub = 4'd4;
  localparam logic [3:0] OpSub2 = 4'd5;
  localparam logic [3:0] OpCmp = 4'd6;
  localparam logic [3:0] OpStp = 4'd7;
  localparam logic [3:0] OpDjp = 4'd8;
  localparam logic [3:0] OpDjr = 4'd9;
  localparam logic [3:0] OpDld = 4'd10;
  localparam logic [3:0] OpDad = 4'd11;
  localparam logic [3:0] OpDsb = 4'd12;
  localparam logic [3:0] OpAdd = 4'd13;
  localparam logic [3:0] OpDiv = 4'd14;
  localparam logic [3:0] OpMul = 4'd15;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  address;
    logic [31:0] data;
  } bspc_in_t;

  typedef struct packed {
    logic        halted;
    logic [2:0]  status;
    logic [31:0] counter;
    logic [31:0] present_instruction;
    logic [31:0] accumulator_value;
  } bspc_out_t;

  // Request to the shift-and-add / restoring-divide unit.
  typedef struct packed {
    logic start;
    logic div;
  } bspc_md_ctl_t;

endpackage

>>> rtl/core/bspc_muldiv.sv
module bspc_muldiv import bspc_pkg::*; #(
  parameter int unsigned MagBits = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bspc_md_ctl_t       ctl_i,
  input  logic [MagBits-1:0] a_i,
  input  logic [MagBits-1:0] b_i,
  output logic               done_o,
  output logic [MagBits-1:0] res_o
);

  localparam int unsigned CntBits = $clog2(MagBits + 1);

  logic               busy_q, busy_d;
  logic               div_q, div_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [MagBits-1:0] acc_q, acc_d;
  logic [MagBits-1:0] opa_q, opa_d;
  logic [MagBits-1:0] opb_q, opb_d;
  logic [MagBits:0]   rem_sh;
  logic               fits;

  // One multiplier bit or one quotient bit per cycle.
  assign rem_sh = {acc_q, opa_q[MagBits-1]};
  assign fits   = rem_sh >= {1'b0, opb_q};

  always_comb begin
    busy_d = busy_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    opa_d  = opa_q;
    opb_d  = opb_q;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      div_d  = ctl_i.div;
      cnt_d  = CntBits'(MagBits);
      acc_d  = '0;
      opa_d  = a_i;
      opb_d  = b_i;
    end else if (busy_q) begin
      if (div_q) begin
        acc_d = fits ? MagBits'(rem_sh - {1'b0, opb_q}) : rem_sh[MagBits-1:0];
        opa_d = {opa_q[MagBits-2:0], fits};
      end else begin
        acc_d = (acc_q << 1) + (opa_q[MagBits-1] ? opb_q : '0);
        opa_d = opa_q << 1;
      end
      cnt_d = cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    acc_q <= acc_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
  end

  assign done_o = busy_q && (cnt_q == CntBits'(1));
  assign res_o  = div_q ? opa_d : acc_d;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !done_o |-> !ctl_i.start) else $error("muldiv restarted while busy");
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q) else $error("muldiv busy after done");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("muldiv count underflow");
`endif

endmodule

>>> rtl/core/baby_stored_program_core.sv
// Sequence: a restart or a step on a halted machine goes straight to the output state, a write
// passes a write state first; a full step passes bump, fetch, decode, operand read and execute,
// a CMP skip adds a second bump, a halt ends it early, and MUL and DIV wait on the muldiv unit.
// Throughput: one transaction at a time; in_ready_o is low until the result is taken.
// Reset: asynchronous, active low; clears counter, accumulator, instruction, lamp, status
// and extended-set flag, sets memory words to 32; the store is swept to zero after reset.
module baby_stored_program_core import bspc_pkg::*; #(
  parameter int unsigned STORE_DEPTH  = 64,
  parameter int unsigned OPERAND_BITS = 13
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  bspc_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output bspc_out_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [6:0] cfg_data_i
);

  localparam int unsigned MagBits = WordBits - 1;
  localparam int unsigned AddrBits = $clog2(STORE_DEPTH);
  localparam int unsigned CntBits  = AddrBits + 1;

  // Sequencer state codes.
  localparam logic [3:0] SClear  = 4'd0;
  localparam logic [3:0] SIdle   = 4'd1;
  localparam logic [3:0] SBump   = 4'd2;
  localparam logic [3:0] SFetch  = 4'd3;
  localparam logic [3:0] SDecode = 4'd4;
  localparam logic [3:0] SOpnd   = 4'd5;
  localparam logic [3:0] SExec   = 4'd6;
  localparam logic [3:0] SMd     = 4'd7;
  localparam logic [3:0] SOut    = 4'd8;
  localparam logic [3:0] SRead   = 4'd9;

  logic [3:0] state_q, state_d;

  logic [WordBits-1:0] store_mem [STORE_DEPTH];
  logic [WordBits-1:0] rd_q;
  logic [AddrBits-1:0] rd_addr;
  logic                we;
  logic [AddrBits-1:0] wr_addr;
  logic [WordBits-1:0] wr_data;
  logic [CntBits-1:0]  clr_q, clr_d;

  logic [WordBits-1:0] ci_q, ci_d, acc_q, acc_d, ir_q, ir_d, s_q, s_d;
  logic                lamp_q, lamp_d;
  logic [2:0]          code_q, code_d;
  logic                ext_q;
  logic [6:0]          mw_q;
  logic [6:0]          in_use;
  logic                skip_q, skip_d;
  logic                out_valid_q, out_valid_d;
  bspc_in_t            req_q, req_d;

  logic [3:0]            opc;
  logic [OPERAND_BITS-1:0] opnd;
  logic                  uses_s;

  // Shared sign-magnitude adder: all instruction add and subtract and the counter increment go through it.
  logic [WordBits-1:0] add_a, add_b, add_r;
  logic                add_negb;
  logic                sa, sb;
  logic [MagBits-1:0]  ma, mb;
  logic                a_ge_b;

  bspc_md_ctl_t       md_ctl;
  logic               md_done;
  logic [MagBits-1:0] md_res;
  logic [MagBits-1:0] md_a, md_b;

  function automatic logic is_neg(input logic [WordBits-1:0] w);
    return w[WordBits-1] && (w[MagBits-1:0] != '0);
  endfunction

  always_comb begin
    ma = add_a[MagBits-1:0];
    mb = add_b[MagBits-1:0];
    sa = is_neg(add_a);
    sb = (mb != '0) && (is_neg(add_b) ^ add_negb);
    a_ge_b = ma >= mb;
    if (sa == sb) begin
      // A sum that wraps to zero magnitude keeps its sign.
      add_r = {sa, MagBits'(ma + mb)};
    end else if (a_ge_b) begin
      add_r = {(ma != mb) && sa, MagBits'(ma - mb)};
    end else begin
      add_r = {sb, MagBits'(mb - ma)};
    end
  end

  assign in_use = (mw_q > 7'(STORE_DEPTH)) ? 7'(STORE_DEPTH) : mw_q;
  assign opc    = ext_q ? ir_q[16:13] : {1'b0, ir_q[15:13]};
  assign opnd   = ir_q[OPERAND_BITS-1:0];
  assign uses_s = (opc <= OpSub2) || (opc >= OpAdd);
  assign md_a   = acc_q[MagBits-1:0];
  assign md_b   = s_q[MagBits-1:0];

  bspc_muldiv #(.MagBits(MagBits)) u_md (
    .clk_i, .rst_ni, .ctl_i(md_ctl), .a_i(md_a), .b_i(md_b),
    .done_o(md_done), .res_o(md_res)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    ci_d        = ci_q;
    acc_d       = acc_q;
    ir_d        = ir_q;
    s_d         = s_q;
    lamp_d      = lamp_q;
    code_d      = code_q;
    skip_d      = skip_q;
    req_d       = req_q;
    out_valid_d = out_valid_q;
    we          = 1'b0;
    wr_addr     = req_q.address[AddrBits-1:0];
    wr_data     = req_q.data;
    rd_addr     = ci_q[AddrBits-1:0];
    add_a       = ci_q;
    add_b       = WordBits'(1);
    add_negb    = 1'b0;
    md_ctl      = '0;
    case (state_q)
      SClear: begin
        we      = 1'b1;
        wr_addr = clr_q[AddrBits-1:0];
        wr_data = '0;
        clr_d   = clr_q + CntBits'(1);
        if (clr_q == CntBits'(STORE_DEPTH - 1)) state_d = SIdle;
      end
      SIdle: begin
        if (in_valid_i) begin
          req_d  = in_data_i;
          skip_d = 1'b0;
          case (in_data_i.action)
            ActWrite:   state_d = SRead;
            ActStep:    state_d = lamp_q ? SOut : SBump;
            ActRestart: begin
              acc_d = '0; ci_d = '0; lamp_d = 1'b0; code_d = StRun;
              state_d = SOut;
            end
            default:    state_d = SOut;
          endcase
        end
      end
      SRead: begin
        if (32'(req_q.address) < STORE_DEPTH) we = 1'b1;
        state_d = SOut;
      end
      SBump: begin
        if (is_neg(add_r) || (add_r[MagBits-1:0] >= MagBits'(in_use))) begin
          lamp_d = 1'b1; code_d = StCiOut; state_d = SOut;
        end else begin
          ci_d = add_r;
          state_d = skip_q ? SOut : SFetch;
        end
      end
      SFetch: state_d = SDecode;
      SDecode: begin
        ir_d = rd_q;
        state_d = SOpnd;
      end
      SOpnd: begin
        rd_addr = opnd[AddrBits-1:0];
        if (!ext_q && ir_q[16]) begin
          lamp_d = 1'b1; code_d = StBadOp; state_d = SOut;
        end else if (uses_s && (32'(opnd) >= 32'(in_use))) begin
          lamp_d = 1'b1; code_d = StOpndOut; state_d = SOut;
        end else begin
          state_d = SExec;
        end
      end
      SExec: begin
        s_d = uses_s ? rd_q : '0;
        state_d = SOut;
        case (opc)
          OpJmp: ci_d = rd_q;
          OpJrp: begin add_a = ci_q; add_b = rd_q; ci_d = add_r; end
          OpLdn: begin add_a = '0; add_b = rd_q; add_negb = 1'b1; acc_d = add_r; end
          OpSto: begin we = 1'b1; wr_addr = opnd[AddrBits-1:0]; wr_data = acc_q; end
          OpSub, OpSub2: begin
            add_a = acc_q; add_b = rd_q; add_negb = 1'b1; acc_d = add_r;
          end
          OpCmp: if (is_neg(acc_q)) begin skip_d = 1'b1; state_d = SBump; end
          OpStp: begin lamp_d = 1'b1; code_d = StStop; end
          OpDjp: ci_d = WordBits'(opnd);
          OpDjr: begin add_a = ci_q; add_b = WordBits'(opnd); ci_d = add_r; end
          OpDld: begin
            add_a = '0; add_b = WordBits'(opnd); add_negb = 1'b1; acc_d = add_r;
          end
          OpDad: begin add_a = acc_q; add_b = WordBits'(opnd); acc_d = add_r; end
          OpDsb: begin
            add_a = acc_q; add_b = WordBits'(opnd); add_negb = 1'b1; acc_d = add_r;
          end
          OpAdd: begin add_a = acc_q; add_b = rd_q; acc_d = add_r; end
          OpDiv: begin
            if (rd_q[MagBits-1:0] == '0) begin
              lamp_d = 1'b1; code_d = StDiv0;
            end else begin
              state_d = SMd;
            end
          end
          default: state_d = SMd;
        endcase
      end
      SMd: begin
        if (skip_q) begin
          md_ctl.start = 1'b1;
          md_ctl.div   = (opc == OpDiv);
          skip_d = 1'b0;
        end
        if (md_done) begin
          // A quotient is negative only when nonzero; a product of factors with unlike signs is
          // negative when both factors are nonzero, even if its magnitude wraps to zero.
          acc_d = {((opc == OpDiv) ? (md_res != '0) : ((md_a != '0) && (md_b != '0))) &&
                   (is_neg(acc_q) != is_neg(s_q)), md_res};
          state_d = SOut;
        end
      end
      SOut: begin
        out_valid_d = 1'b1;
        if (out_valid_q && out_ready_i) begin
          out_valid_d = 1'b0;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
    // Entering the multiply/divide wait: arm a one-cycle start.
    if (state_q == SExec && state_d == SMd) skip_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (we) store_mem[wr_addr] <= wr_data;
    rd_q <= store_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_q       <= '0;
      ci_q        <= '0;
      acc_q       <= '0;
      ir_q        <= '0;
      lamp_q      <= 1'b0;
      code_q      <= StRun;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      ext_q       <= 1'b0;
      mw_q        <= 7'd32;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      ci_q        <= ci_d;
      acc_q       <= acc_d;
      ir_q        <= ir_d;
      lamp_q      <= lamp_d;
      code_q      <= code_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgExtSet) ext_q <= cfg_data_i[0];
        else mw_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    s_q   <= s_d;
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = '{halted: lamp_q, status: code_q, counter: ci_q,
                         present_instruction: ir_q, accumulator_value: acc_q};

`ifndef SYNTHESIS
  a_lamp_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (lamp_q == (code_q != StRun))) else $error("lamp and status disagree");
  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == SOut) else $error("result outside output state");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready while result pending");
`endif

endmodule

>>> tb/tb_baby_stored_program_core.sv
module tb_baby_stored_program_core;
  import bspc_pkg::*;

  // Action code with no meaning; the block must answer with its current state.
  localparam logic [1:0] ActNone = 2'd3;

  // Scoreboard for the stored-program core. It carries its own copy of the
  // machine (store, counter, accumulator, present instruction, stop lamp and
  // status) and of both configuration registers. Every accepted input
  // transaction is run through this copy, and the resulting machine state is
  // queued as the expected output transaction.
  class spc_scoreboard;
    logic [31:0] mem [64];
    logic [31:0] ci;
    logic [31:0] acc;
    logic [31:0] ir;
    bit          lamp;
    logic [2:0]  code;
    bit          ext;
    int unsigned mw;
    bspc_out_t   pending[$];
    int unsigned fails;
    int unsigned checked;
    int unsigned steps_run;

    function new();
      foreach (mem[i]) mem[i] = '0;
      ci = '0;
      acc = '0;
      ir = '0;
      lamp = 0;
      code = StRun;
      ext = 0;
      mw = 32;
      fails = 0;
      checked = 0;
      steps_run = 0;
    endfunction

    function void set_cfg(logic idx, logic [6:0] val);
      if (idx == CfgExtSet) ext = val[0];
      else mw = val;
    endfunction

    function int unsigned words();
      return (mw > 64) ? 64 : mw;
    endfunction

    function bit is_neg(logic [31:0] w);
      return w[31] && (w[30:0] != '0);
    endfunction

    function logic [31:0] mk(bit neg, logic [63:0] mag);
      return {neg, mag[30:0]};
    endfunction

    // Exact signed sum of two sign-magnitude values; the magnitude wraps.
    function logic [31:0] add_sm(bit sa, logic [63:0] ma, bit sb, logic [63:0] mb);
      if (ma == 0) sa = 0;
      if (mb == 0) sb = 0;
      if (sa == sb) begin
        if (ma == 0 && mb == 0) return '0;
        return mk(sa, ma + mb);
      end
      if (ma >= mb) return mk((ma != mb) && sa, ma - mb);
      return mk(sb, mb - ma);
    endfunction

    function logic [31:0] add_words(logic [31:0] a, logic [31:0] b, bit neg_b);
      bit sb;
      sb = is_neg(b);
      return add_sm(is_neg(a), a[30:0], neg_b ? !sb : sb, b[30:0]);
    endfunction

    function void halt(logic [2:0] c);
      lamp = 1;
      code = c;
    endfunction

    // Counter increment; a counter that leaves the store halts the machine.
    function bit bump();
      logic [31:0] nxt;
      nxt = add_sm(is_neg(ci), ci[30:0], 0, 1);
      if (is_neg(nxt) || nxt[30:0] >= words()) begin
        halt(StCiOut);
        return 0;
      end
      ci = nxt;
      return 1;
    endfunction

    function void run_step();
      logic [3:0]  opc;
      logic [31:0] opnd;
      logic [31:0] s;
      logic [63:0] ma;
      logic [63:0] ms;
      bit          sg;
      if (lamp) return;
      if (!bump()) return;
      steps_run++;
      ir = mem[ci[5:0]];
      if (ext) begin
        opc = ir[16:13];
      end else begin
        if (ir[16]) begin
          halt(StBadOp);
          return;
        end
        opc = {1'b0, ir[15:13]};
      end
      opnd = {19'b0, ir[12:0]};
      s = '0;
      if (opc <= OpSub2 || opc >= OpAdd) begin
        if (opnd >= words()) begin
          halt(StOpndOut);
          return;
        end
        s = mem[opnd[5:0]];
      end
      case (opc)
        OpJmp: ci = s;
        OpJrp: ci = add_words(ci, s, 0);
        OpLdn: acc = add_sm(0, 0, !is_neg(s), s[30:0]);
        OpSto: mem[opnd[5:0]] = acc;
        OpSub, OpSub2: acc = add_words(acc, s, 1);
        OpCmp: if (is_neg(acc)) void'(bump());
        OpStp: halt(StStop);
        OpDjp: ci = mk(0, opnd);
        OpDjr: ci = add_sm(is_neg(ci), ci[30:0], 0, opnd);
        OpDld: acc = add_sm(0, 0, 1, opnd);
        OpDad: acc = add_sm(is_neg(acc), acc[30:0], 0, opnd);
        OpDsb: acc = add_sm(is_neg(acc), acc[30:0], 1, opnd);
        OpAdd: acc = add_words(acc, s, 0);
        OpDiv: begin
          ms = s[30:0];
          if (ms == 0) begin
            halt(StDiv0);
          end else begin
            ma = acc[30:0] / ms;
            sg = (ma != 0) && (is_neg(acc) != is_neg(s));
            acc = mk(sg, ma);
          end
        end
        default: begin
          ma = acc[30:0];
          ms = s[30:0];
          sg = (ma != 0) && (ms != 0) && (is_neg(acc) != is_neg(s));
          acc = mk(sg, ma * ms);
        end
      endcase
    endfunction

    function void note_input(bspc_in_t it);
      bspc_out_t exp_out;
      case (it.action)
        ActWrite: mem[it.address] = it.data;
        ActStep: run_step();
        ActRestart: begin
          acc = '0;
          ci = '0;
          lamp = 0;
          code = StRun;
        end
        default: ;
      endcase
      exp_out.halted = lamp;
      exp_out.status = code;
      exp_out.counter = ci;
      exp_out.present_instruction = ir;
      exp_out.accumulator_value = acc;
      pending = {pending, exp_out};
    endfunction

    function void check_result(bspc_out_t got);
      bspc_out_t want;
      checked++;
      if (pending.size() == 0) begin
        fails++;
        if (fails <= 10) $display("ERROR: output transaction with nothing expected: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.halted !== want.halted || got.status !== want.status ||
          got.counter !== want.counter ||
          got.present_instruction !== want.present_instruction ||
          got.accumulator_value !== want.accumulator_value) begin
        fails++;
        if (fails <= 10) begin
          $display("ERROR: mismatch on output transaction %0d", checked);
          $display("  expected halted=%0d status=%0d ci=%h pi=%h acc=%h", want.halted,
                   want.status, want.counter, want.present_instruction,
                   want.accumulator_value);
          $display("  actual   halted=%0d status=%0d ci=%h pi=%h acc=%h", got.halted,
                   got.status, got.counter, got.present_instruction, got.accumulator_value);
        end
      end
    endfunction
  endclass

  localparam int unsigned IdleLimit = 20000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  bspc_in_t   in_data;
  logic       out_valid;
  logic       out_ready;
  bspc_out_t  out_data;
  logic       cfg_we;
  logic       cfg_idx;
  logic [6:0] cfg_data;

  spc_scoreboard sb = new();
  int unsigned   sent;
  int unsigned   idle_cycles;
  bit            no_gaps;

  baby_stored_program_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Idle lengths: mostly none or short, occasionally long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Output side: ready is driven at the falling edge, with random stalls.
  int unsigned stall_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_ready <= 1'b1;
    end
  end

  // Both handshakes are sampled at the rising edge; the watchdog counts
  // cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles + 1 >= IdleLimit) begin
          $display("ERROR: watchdog expired, no transaction for %0d cycles", IdleLimit);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  // Sends one input transaction. Valid is only lowered when a gap is chosen,
  // so back-to-back transactions keep it high across the boundary.
  task automatic send(logic [1:0] act, logic [5:0] addr, logic [31:0] dat);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= '{action: act, address: addr, data: dat};
    do @(posedge clk); while (!in_ready);
    sb.note_input('{action: act, address: addr, data: dat});
    sent++;
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Waits until every expected result has come back, then lets the block
  // settle for a full MUL/DIV latency before the configuration changes.
  task automatic drain();
    go_idle();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [6:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_cfg(idx, val);
  endtask

  function automatic logic [31:0] instr(logic [3:0] op, int unsigned opnd);
    return {15'b0, op, 13'(opnd)};
  endfunction

  // Random instruction word. Most operands land inside the store; the
  // unused upper bits sometimes carry noise, and in base mode bit 16 is seldom set.
  function automatic logic [31:0] rand_instr();
    logic [31:0] w;
    w = $urandom();
    if ($urandom_range(0, 9) < 7) w[12:0] = 13'($urandom_range(0, sb.words() - 1));
    if (!sb.ext && $urandom_range(0, 19) != 0) w[16] = 1'b0;
    if ($urandom_range(0, 2) != 0) w[31:17] = '0;
    return w;
  endfunction

  // Random data word: small signed values dominate so that arithmetic stays
  // interesting; zero, negative zero and full-width noise also appear.
  function automatic logic [31:0] rand_data();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return 32'h8000_0000;
    if (r < 4) return $urandom();
    return {1'($urandom_range(0, 1)), 31'($urandom_range(0, 300))};
  endfunction

  // One program: restart, load a few words from address 1 on (the first
  // step fetches word 1), scatter data words, then step the machine.
  task automatic run_program();
    int unsigned len;
    int unsigned nsteps;
    int unsigned r;
    no_gaps = ($urandom_range(0, 3) == 0);
    send(ActRestart, 6'($urandom()), $urandom());
    len = $urandom_range(1, 10);
    for (int unsigned i = 1; i <= len; i++) send(ActWrite, 6'(i), rand_instr());
    repeat ($urandom_range(0, 4))
      send(ActWrite, 6'($urandom_range(0, sb.words() - 1)), rand_data());
    nsteps = $urandom_range(3, 25);
    for (int unsigned i = 0; i < nsteps; i++) begin
      r = $urandom_range(0, 29);
      if (r == 0) send(ActNone, 6'($urandom()), $urandom());
      else if (r == 1) send(ActWrite, 6'($urandom()), $urandom());
      else if (r == 2) send(ActRestart, 6'($urandom()), $urandom());
      else send(ActStep, 6'($urandom()), $urandom());
    end
    no_gaps = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = CfgExtSet;
    cfg_data = '0;
    out_ready = 1'b0;
    stall_left = 0;
    idle_cycles = 0;
    sent = 0;
    no_gaps = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_cfg(CfgExtSet, 7'd0);
    write_cfg(CfgMemWords, 7'd32);

    // Directed program in the base set: load the negation of a negative value,
    // subtract, take the skip on a negative accumulator, store, then stop. A
    // restart, an unused action code and a word with bit 16 set follow.
    send(ActWrite, 6'd30, 32'h8000_0005);
    send(ActWrite, 6'd31, 32'd7);
    send(ActWrite, 6'd1, instr(OpLdn, 30));
    send(ActWrite, 6'd2, instr(OpSub, 31));
    send(ActWrite, 6'd3, instr(OpCmp, 0));
    send(ActWrite, 6'd4, instr(OpStp, 0));
    send(ActWrite, 6'd5, instr(OpSto, 29));
    send(ActWrite, 6'd6, instr(OpStp, 0));
    repeat (6) send(ActStep, '0, '0);
    send(ActRestart, '0, '0);
    send(ActNone, 6'h3f, 32'hffff_ffff);
    send(ActWrite, 6'd1, 32'h0001_0000);
    send(ActStep, '0, '0);
    send(ActWrite, 6'd63, 32'hffff_ffff);
    send(ActWrite, 6'd0, 32'h0000_0000);
    send(ActRestart, '0, '0);
    drain();

    // Random phases over several settings, the extremes among them.
    for (int unsigned ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_cfg(CfgExtSet, 7'd1); write_cfg(CfgMemWords, 7'd64); end
        1: begin write_cfg(CfgExtSet, 7'd0); write_cfg(CfgMemWords, 7'd32); end
        2: begin write_cfg(CfgExtSet, 7'd1); write_cfg(CfgMemWords, 7'd32); end
        3: begin write_cfg(CfgExtSet, 7'd0); write_cfg(CfgMemWords, 7'd64); end
        default: begin
          write_cfg(CfgExtSet, 7'($urandom_range(0, 1)));
          write_cfg(CfgMemWords, 7'($urandom_range(33, 63)));
        end
      endcase
      while (sent < 25 + (ph + 1) * 255) run_program();
      drain();
    end

    go_idle();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Run covered %0d input transactions, %0d checked results, %0d machine steps,",
             sent, sb.checked, sb.steps_run);
    $display("across base and extended opcode sets with 32 to 64 store words in use.");
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.fails, sb.pending.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
